@@ rtl/rtt_pkg.sv @@
package rtt_pkg;

  localparam int unsigned Tags     = 16;
  localparam int unsigned WordBits = 64;
  localparam int unsigned TagIdxW  = (Tags > 1) ? $clog2(Tags) : 1;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned TagW    = 8;
  localparam int unsigned FieldW  = 64;
  localparam int unsigned StatusW = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC    = 3'd0,
    CMD_FREE     = 3'd1,
    CMD_ISSUE    = 3'd2,
    CMD_COMPLETE = 3'd3,
    CMD_READ     = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NONE_FREE = 3'd1,
    ST_RANGE     = 3'd2,
    ST_UNUSED    = 3'd3,
    ST_NOT_DONE  = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [TagW-1:0]   tag;
    logic [FieldW-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TagW-1:0]    granted_tag;
    logic [FieldW-1:0]  command_word;
    logic [FieldW-1:0]  completion_word;
    logic               notify;
  } rsp_t;

  typedef struct packed {
    status_e         status;
    logic [TagW-1:0] granted_tag;
    logic            cmd_we;
    logic            cpl_we;
    logic            rd_ok;
    logic            notify;
  } dec_t;

endpackage

@@ rtl/rtt_ram.sv @@
module rtt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/rtt_tag_table.sv @@
module rtt_tag_table import rtt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  req_t req_i,
  output dec_t dec_o
);

  logic [Tags-1:0]    in_use_q, in_use_d;
  logic [Tags-1:0]    done_q, done_d;
  logic               in_range;
  logic [TagIdxW-1:0] idx;
  logic [TagIdxW-1:0] free_idx;
  logic               free_found;

  assign in_range = {1'b0, req_i.tag} < (TagW + 1)'(Tags);
  assign idx      = req_i.tag[TagIdxW-1:0];

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = Tags - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx   = TagIdxW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    in_use_d          = in_use_q;
    done_d            = done_q;
    dec_o.status      = ST_OK;
    dec_o.granted_tag = req_i.tag;
    dec_o.cmd_we      = 1'b0;
    dec_o.cpl_we      = 1'b0;
    dec_o.rd_ok       = 1'b0;
    dec_o.notify      = 1'b0;
    case (req_i.command)
      CMD_ALLOC: begin
        if (free_found) begin
          dec_o.granted_tag  = TagW'(free_idx);
          in_use_d[free_idx] = 1'b1;
        end else begin
          dec_o.status      = ST_NONE_FREE;
          dec_o.granted_tag = '0;
        end
      end
      CMD_FREE: begin
        if (!in_range) begin
          dec_o.status = ST_RANGE;
        end else if (!in_use_q[idx]) begin
          dec_o.status = ST_UNUSED;
        end else begin
          in_use_d[idx] = 1'b0;
          done_d[idx]   = 1'b0;
        end
      end
      CMD_ISSUE: begin
        if (!in_range) begin
          dec_o.status = ST_RANGE;
        end else if (!in_use_q[idx]) begin
          dec_o.status = ST_UNUSED;
        end else begin
          dec_o.cmd_we = 1'b1;
        end
      end
      CMD_COMPLETE: begin
        if (!in_range) begin
          dec_o.status = ST_RANGE;
        end else begin
          dec_o.cpl_we = 1'b1;
          dec_o.notify = 1'b1;
          done_d[idx]  = 1'b1;
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          dec_o.status = ST_RANGE;
        end else if (!done_q[idx]) begin
          dec_o.status = ST_NOT_DONE;
        end else begin
          dec_o.rd_ok = 1'b1;
        end
      end
      default: begin
        dec_o.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      done_q   <= '0;
    end else if (accept_i) begin
      in_use_q <= in_use_d;
      done_q   <= done_d;
    end
  end

endmodule

@@ rtl/request_tag_tracker_unit.sv @@
// Request tag tracker.
// Requests enter on req_i (command, tag, payload) and are taken at a rising
// edge where start is high and busy is low. Commands: allocate the lowest
// free tag, free a used tag, issue (store a command word), complete (store a
// completion word, mark done, raise notify) and read both words of a done tag.
// Every request gives exactly one result on result_o, shown for one cycle
// with valid_o high; the receiver cannot stall and must take it then.
// dec_q and the word memories' read data are registered at the accepting
// edge, result_o and valid_o from them as busy ends. busy, high in the cycle
// after accept, holds off new requests while the memories deliver data.
// Used and done marks live in flops and are decided in the accept cycle;
// the command and completion words live in two single-port-read RAMs that
// are written in the accept cycle, so a later read always sees them.
// Reset clears all marks, the state machine and valid_o; stored words are
// not cleared and are undefined until written.
module request_tag_tracker_unit import rtt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic valid_o,
  output rsp_t result_o
);

  state_e              state_q, state_d;
  logic                accept;
  dec_t                dec;
  dec_t                dec_q;
  logic [WordBits-1:0] cmd_rdata, cpl_rdata;
  logic                valid_q;
  rsp_t                rsp_q;

  assign busy   = (state_q == ST_BUSY);
  assign accept = start && !busy;

  rtt_tag_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .dec_o    (dec)
  );

  rtt_ram #(
    .Width (WordBits),
    .Depth (Tags)
  ) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (accept && dec.cmd_we),
    .waddr_i (req_i.tag[TagIdxW-1:0]),
    .wdata_i (req_i.payload[WordBits-1:0]),
    .raddr_i (req_i.tag[TagIdxW-1:0]),
    .rdata_o (cmd_rdata)
  );

  rtt_ram #(
    .Width (WordBits),
    .Depth (Tags)
  ) u_cpl_ram (
    .clk_i   (clk_i),
    .we_i    (accept && dec.cpl_we),
    .waddr_i (req_i.tag[TagIdxW-1:0]),
    .wdata_i (req_i.payload[WordBits-1:0]),
    .raddr_i (req_i.tag[TagIdxW-1:0]),
    .rdata_o (cpl_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q <= dec;
    end
    if (busy) begin
      rsp_q.status          <= dec_q.status;
      rsp_q.granted_tag     <= dec_q.granted_tag;
      rsp_q.command_word    <= dec_q.rd_ok ? FieldW'(cmd_rdata) : '0;
      rsp_q.completion_word <= dec_q.rd_ok ? FieldW'(cpl_rdata) : '0;
      rsp_q.notify          <= dec_q.notify;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = rsp_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accepted request");

  a_busy_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> valid_o)
    else $error("no result after busy cycle");

  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while busy");

  a_notify_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.notify) |-> (result_o.status == ST_OK))
    else $error("notify with error status");

endmodule
